### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define LSTC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("assertion failed");
`define LSTC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication failed");
`else
`define LSTC_ASSERT(lbl, prop)
`define LSTC_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

### sv/lstc_pkg.sv
// ----------------------------------------------------------------------------
// lstc_pkg
// Constants and types for the LED strobe timer calculator.
// ----------------------------------------------------------------------------
package lstc_pkg;
	localparam int unsigned TIMER_CLOCK_HZ  = 170000000;
	localparam int unsigned TIMER_CLOCK_MHZ = 170;
	localparam int unsigned PRESCALER_SPAN  = 65536;

	// divider width: timer clock in Hz fits in 28 bits
	localparam int DIV_W = 28;
	localparam int CNT_W = 5;

	localparam logic [DIV_W-1:0] CLK_HZ_C   = DIV_W'(TIMER_CLOCK_HZ);
	localparam logic [DIV_W-1:0] PSC_NUM_C  = DIV_W'(TIMER_CLOCK_HZ / PRESCALER_SPAN);
	localparam logic [DIV_W-1:0] DUTY_C     = DIV_W'(100000);
	localparam logic [DIV_W-1:0] HALF45_C   = DIV_W'(225000);
	localparam logic [7:0]       MHZ_C      = 8'(TIMER_CLOCK_MHZ);
	localparam logic [15:0]      MAX16_C    = 16'hffff;

	localparam logic [15:0] MAX_ON_RST_C   = 16'd5000;
	localparam logic [15:0] MAX_RATE_RST_C = 16'd60;

	typedef enum logic [1:0] {
		REQ_MAIN   = 2'd0,
		REQ_RATE   = 2'd1,
		REQ_SECOND = 2'd2,
		REQ_BAD    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_INVALID   = 2'd1,
		ST_UNREACH   = 2'd2,
		ST_RSVD      = 2'd3
	} status_t;

	localparam logic CFG_MAX_ON   = 1'b0;
	localparam logic CFG_MAX_RATE = 1'b1;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b0000_0000_0001,
		S_DISP   = 12'b0000_0000_0010,
		S_FMAX   = 12'b0000_0000_0100,
		S_LIM    = 12'b0000_0000_1000,
		S_PSC    = 12'b0000_0001_0000,
		S_MUL    = 12'b0000_0010_0000,
		S_ARR    = 12'b0000_0100_0000,
		S_CCR    = 12'b0000_1000_0000,
		S_LIM2   = 12'b0001_0000_0000,
		S_CCR2   = 12'b0010_0000_0000,
		S_COMMIT = 12'b0100_0000_0000,
		S_DONE   = 12'b1000_0000_0000
	} state_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic             busy;
		logic [DIV_W-1:0] quotient;
	} div_rsp_t;

	function automatic logic [15:0] sat16(input logic [DIV_W-1:0] v);
		return (|v[DIV_W-1:16]) ? MAX16_C : v[15:0];
	endfunction
endpackage

### sv/lstc_div.sv
// ----------------------------------------------------------------------------
// lstc_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lstc_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lstc_pkg::div_req_t req,
	output lstc_pkg::div_rsp_t rsp
);
	import lstc_pkg::*;

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   shifted;
	logic [DIV_W+1:0] diff;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			rem_q <= diff[DIV_W+1] ? shifted[DIV_W-1:0] : diff[DIV_W-1:0];
			quo_q <= {quo_q[DIV_W-2:0], ~diff[DIV_W+1]};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.busy     = busy_q;
	assign rsp.quotient = quo_q;
endmodule

### sv/led_strobe_timer_calc.sv
// ----------------------------------------------------------------------------
// led_strobe_timer_calc
// LED strobe timer record: prescaler, period and compare values from requests.
// ----------------------------------------------------------------------------
// Sequencing: requests needing no division go from S_DISP straight to S_DONE, and a
//   frame rate change runs up to six 28-bit divisions on the shared divider.
// One request at a time: s_tready is high only in S_IDLE, which is entered together
//   with m_tvalid going high; S_DONE holds while the result register is still full.
// Reset: arst_n clears the record and the sequencer, loads max_on_time_us=5000
//   and max_frame_rate=60.
`include "assert_macros.svh"
module led_strobe_timer_calc (
	input  logic        clk,
	input  logic        arst_n,
	// request channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] request_value
	input  logic [1:0]  s_tuser,  // [1:0] req_type
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [87:0] m_tdata,  // status, frame_rate_out, prescaler_out, period_out,
	                              // compare_main_out, compare_second_out, zero pad
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import lstc_pkg::*;

	// config registers
	logic [15:0] max_on_q, max_rate_q;

	// timer record
	logic [15:0] frame_rate_q;
	logic [11:0] prescaler_q;   // never exceeds 2593
	logic [15:0] period_q;
	logic [15:0] cmp_main_q;
	logic [15:0] cmp_second_q;
	logic [15:0] on_main_q;
	logic [31:0] on_second_q;

	// transaction working set
	state_t      state_q;
	req_t        typ_q;
	logic [31:0] val_q;
	logic [15:0] rate_q;        // frame rate used for this transaction
	logic [16:0] fmax_q;
	logic [11:0] psc_w_q;
	logic [27:0] prod_q;
	logic [15:0] arr_w_q;
	logic [15:0] ccr_w_q;
	logic [15:0] ccr2_w_q;
	logic [17:0] lim2_q;
	status_t     st_q;
	logic        launched_q;

	logic        m_tvalid_q;
	logic [87:0] m_tdata_q;

	div_req_t    dreq;
	div_rsp_t    drsp;
	logic        div_state;
	logic [15:0] on_eff;
	logic [17:0] on2_clamp;
	logic [12:0] psc_p1;
	logic [27:0] q;
	logic [16:0] lim;

	lstc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	assign q      = drsp.quotient;
	assign psc_p1 = {1'b0, psc_w_q} + 13'd1;
	assign on_eff = (typ_q == REQ_MAIN) ? val_q[15:0] : on_main_q;
	// second LED on-time clamped at 45% of the half period
	assign on2_clamp = (on_second_q < {14'd0, lim2_q}) ? on_second_q[17:0] : lim2_q;
	// duty limit capped by the largest on-time
	assign lim = (q[16:0] > {1'b0, max_on_q}) ? {1'b0, max_on_q} : q[16:0];

	assign div_state = (state_q == S_FMAX) || (state_q == S_LIM) || (state_q == S_PSC) ||
		(state_q == S_ARR) || (state_q == S_CCR) || (state_q == S_LIM2) ||
		(state_q == S_CCR2);

	// divider operand select, one division per state
	always_comb begin
		dreq.start    = div_state && !launched_q;
		dreq.dividend = '0;
		dreq.divisor  = 28'd1;
		case (state_q)
			S_FMAX: begin
				dreq.dividend = DUTY_C;
				dreq.divisor  = {12'd0, val_q[15:0]};
			end
			S_LIM: begin
				dreq.dividend = DUTY_C;
				dreq.divisor  = {12'd0, rate_q};
			end
			S_PSC: begin
				dreq.dividend = PSC_NUM_C;
				dreq.divisor  = (typ_q == REQ_MAIN && prescaler_q != 12'd0) ?
					{11'd0, fmax_q} : {12'd0, rate_q};
			end
			S_ARR: begin
				dreq.dividend = CLK_HZ_C;
				dreq.divisor  = prod_q;
			end
			S_CCR: begin
				dreq.dividend = {12'd0, on_eff} * {20'd0, MHZ_C};
				dreq.divisor  = {15'd0, psc_p1};
			end
			S_LIM2: begin
				dreq.dividend = HALF45_C;
				dreq.divisor  = {12'd0, rate_q};
			end
			S_CCR2: begin
				dreq.dividend = {10'd0, on2_clamp} * {20'd0, MHZ_C};
				dreq.divisor  = {15'd0, psc_p1};
			end
			default: begin
				dreq.dividend = '0;
				dreq.divisor  = 28'd1;
			end
		endcase
	end

	assign s_tready = (state_q == S_IDLE);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_on_q   <= MAX_ON_RST_C;
			max_rate_q <= MAX_RATE_RST_C;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAX_ON:   max_on_q   <= cfg_data;
				CFG_MAX_RATE: max_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and record
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			launched_q   <= 1'b0;
			st_q         <= ST_OK;
			frame_rate_q <= '0;
			prescaler_q  <= '0;
			period_q     <= '0;
			cmp_main_q   <= '0;
			cmp_second_q <= '0;
			on_main_q    <= '0;
			on_second_q  <= '0;
			m_tvalid_q   <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready)
				m_tvalid_q <= 1'b0;
			if (dreq.start)
				launched_q <= 1'b1;
			if (drsp.done)
				launched_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (s_tvalid)
						state_q <= S_DISP;
				end
				S_DISP: begin
					st_q    <= ST_OK;
					state_q <= S_DONE;
					case (typ_q)
						REQ_MAIN: begin
							if (val_q == 32'd0) begin
								cmp_main_q <= '0;
								on_main_q  <= '0;
							end else if (val_q > {16'd0, max_on_q}) begin
								st_q <= ST_INVALID;
							end else if (frame_rate_q == 16'd0) begin
								on_main_q <= val_q[15:0];
							end else begin
								rate_q  <= frame_rate_q;
								state_q <= S_FMAX;
							end
						end
						REQ_RATE: begin
							if (val_q == 32'd0) begin
								frame_rate_q <= '0;
								prescaler_q  <= '0;
								period_q     <= '0;
								cmp_main_q   <= '0;
								cmp_second_q <= '0;
							end else if (val_q > {16'd0, max_rate_q}) begin
								st_q <= ST_INVALID;
							end else if (on_main_q == 16'd0 && on_second_q == 32'd0) begin
								frame_rate_q <= val_q[15:0];
							end else begin
								rate_q  <= val_q[15:0];
								state_q <= (on_main_q != 16'd0) ? S_LIM : S_PSC;
							end
						end
						REQ_SECOND: begin
							on_second_q <= val_q;
							if (frame_rate_q != 16'd0) begin
								rate_q  <= frame_rate_q;
								state_q <= S_PSC;
							end
						end
						default: st_q <= ST_INVALID;
					endcase
				end
				S_FMAX: begin
					if (drsp.done) begin
						fmax_q <= q[16:0];
						if (q[16:0] < {1'b0, rate_q}) begin
							st_q    <= ST_INVALID;
							state_q <= S_DONE;
						end else begin
							state_q <= S_PSC;
						end
					end
				end
				S_LIM: begin
					if (drsp.done) begin
						if (lim < {1'b0, on_main_q}) begin
							st_q    <= ST_INVALID;
							state_q <= S_DONE;
						end else begin
							state_q <= S_PSC;
						end
					end
				end
				S_PSC: begin
					if (drsp.done) begin
						// a main on-time change never lowers the prescaler
						if (typ_q == REQ_MAIN && prescaler_q > q[11:0])
							psc_w_q <= prescaler_q;
						else
							psc_w_q <= q[11:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					prod_q  <= {15'd0, psc_p1} * {12'd0, rate_q};
					state_q <= S_ARR;
				end
				S_ARR: begin
					if (drsp.done) begin
						arr_w_q <= sat16(q);
						if (typ_q == REQ_MAIN) begin
							if (|q[27:16]) begin
								st_q    <= ST_UNREACH;
								state_q <= S_DONE;
							end else begin
								state_q <= S_CCR;
							end
						end else if (typ_q == REQ_RATE && on_main_q != 16'd0) begin
							state_q <= S_CCR;
						end else begin
							state_q <= S_LIM2;
						end
					end
				end
				S_CCR: begin
					if (drsp.done) begin
						ccr_w_q <= (q == 28'd0) ? 16'd1 : sat16(q);
						if (typ_q == REQ_RATE && on_second_q != 32'd0)
							state_q <= S_LIM2;
						else
							state_q <= S_COMMIT;
					end
				end
				S_LIM2: begin
					if (drsp.done) begin
						lim2_q  <= q[17:0];
						state_q <= S_CCR2;
					end
				end
				S_CCR2: begin
					if (drsp.done) begin
						ccr2_w_q <= sat16(q);
						state_q  <= S_COMMIT;
					end
				end
				S_COMMIT: begin
					prescaler_q <= psc_w_q;
					period_q    <= arr_w_q;
					case (typ_q)
						REQ_MAIN: begin
							on_main_q  <= val_q[15:0];
							cmp_main_q <= ccr_w_q;
						end
						REQ_RATE: begin
							frame_rate_q <= rate_q;
							if (on_main_q != 16'd0)
								cmp_main_q <= ccr_w_q;
							if (on_second_q != 32'd0)
								cmp_second_q <= ccr2_w_q;
						end
						default: cmp_second_q <= ccr2_w_q;
					endcase
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the result register is free
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and result payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			typ_q <= req_t'(s_tuser);
			val_q <= s_tdata;
		end
		if (state_q == S_DONE && (!m_tvalid_q || m_tready))
			m_tdata_q <= {6'd0, cmp_second_q, cmp_main_q, period_q, 4'd0, prescaler_q,
				frame_rate_q, st_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`LSTC_ASSERT_IMP(a_start_idle_div, dreq.start, !drsp.busy)
	`LSTC_ASSERT_IMP(a_accept_disp, s_tvalid && s_tready, ##1 state_q == S_DISP)
	`LSTC_ASSERT(a_psc_range, prescaler_q <= 12'd2593)
	`LSTC_ASSERT_IMP(a_done_in_div, drsp.done, div_state && launched_q)
endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for led_strobe_timer_calc. It sends request
// transactions with random gaps and stalls on both stream sides. A built-in
// timer-record predictor models every request, and each result transaction
// is compared field by field with the oldest expected record.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import lstc_pkg::*;

	localparam longint unsigned CYCLE_LIMIT = 3000000;
	localparam int              DRAIN_CYCLES = 300;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [87:0] m_tdata;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	led_strobe_timer_calc uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// one timer record as seen on the result channel
	typedef struct {
		status_t     status;
		logic [15:0] rate;
		logic [15:0] psc;
		logic [15:0] arr;
		logic [15:0] ccr_main;
		logic [15:0] ccr_second;
	} record_t;

	// directed stimulus row; typed == 1 means the expected record is given here
	typedef struct {
		req_t        req;
		logic [31:0] value;
		bit          typed;
		record_t     rec;
	} row_t;

	record_t     record_q[$];
	int          mismatches = 0;
	int          results_seen = 0;
	int          sent = 0;
	bit          rx_jitter = 1;
	bit          tx_jitter = 1;
	int          rx_holdoff = 0;  // pending long receiver stall, in cycles
	longint unsigned cycles = 0;

	// predictor copy of the configuration and record
	logic [15:0] lim_on_us, lim_rate;
	logic [15:0] p_rate, p_psc, p_arr, p_ccr, p_ccr2, p_on;
	logic [31:0] p_on2;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic logic [15:0] clip16(longint unsigned v);
		return (v > 64'hffff) ? 16'hffff : v[15:0];
	endfunction

	function automatic logic [15:0] psc_of_rate(longint unsigned f);
		return clip16(longint'(TIMER_CLOCK_HZ) / (longint'(PRESCALER_SPAN) * f));
	endfunction

	function automatic longint unsigned arr_of(longint unsigned psc, longint unsigned f);
		return longint'(TIMER_CLOCK_HZ) / ((psc + 1) * f);
	endfunction

	function automatic logic [15:0] ticks_of(longint unsigned on_us, longint unsigned psc);
		return clip16((longint'(TIMER_CLOCK_MHZ) * on_us) / (psc + 1));
	endfunction

	// second LED is clamped at 45% of the half period
	function automatic logic [15:0] second_ticks(longint unsigned f, longint unsigned psc,
		longint unsigned on2);
		longint unsigned cap;
		cap = 225000 / f;
		return ticks_of((on2 < cap) ? on2 : cap, psc);
	endfunction

	// timer-record update for one request; returns the status
	function automatic status_t update_record(req_t req, logic [31:0] v);
		longint unsigned t, fmax, psc, arr, cap;
		logic [15:0] ccr, ccr2;
		t = v;
		case (req)
			REQ_MAIN: begin
				if (t == 0) begin
					p_ccr = 0;
					p_on = 0;
					return ST_OK;
				end
				if (t > lim_on_us) return ST_INVALID;
				if (p_rate == 0) begin
					p_on = t[15:0];
					return ST_OK;
				end
				fmax = 100000 / t;
				if (fmax < p_rate) return ST_INVALID;
				psc = (fmax != 0) ? psc_of_rate(fmax) : 0;
				if (p_psc == 0) psc = psc_of_rate(p_rate);
				if (p_psc > psc) psc = p_psc;
				arr = arr_of(psc, p_rate);
				if (arr > 64'hffff) return ST_UNREACH;
				p_psc = psc[15:0];
				p_arr = arr[15:0];
				p_on = t[15:0];
				p_ccr = ticks_of(t, psc);
				if (p_ccr == 0) p_ccr = 1;
				return ST_OK;
			end
			REQ_RATE: begin
				if (t == 0) begin
					p_rate = 0; p_psc = 0; p_arr = 0; p_ccr = 0; p_ccr2 = 0;
					return ST_OK;
				end
				if (t > lim_rate) return ST_INVALID;
				if (p_on == 0 && p_on2 == 0) begin
					p_rate = t[15:0];
					return ST_OK;
				end
				psc = psc_of_rate(t);
				ccr = p_ccr;
				ccr2 = p_ccr2;
				if (p_on != 0) begin
					cap = 100000 / t;
					if (cap > lim_on_us) cap = lim_on_us;
					if (cap < p_on) return ST_INVALID;
					ccr = ticks_of(p_on, psc);
					if (p_on2 != 0) ccr2 = second_ticks(t, psc, p_on2);
					if (ccr == 0) ccr = 1;
				end else begin
					ccr2 = second_ticks(t, psc, p_on2);
				end
				p_rate = t[15:0];
				p_psc = psc[15:0];
				p_arr = clip16(arr_of(psc, t));
				p_ccr = ccr;
				p_ccr2 = ccr2;
				return ST_OK;
			end
			REQ_SECOND: begin
				p_on2 = v;
				if (p_rate != 0) begin
					p_psc = psc_of_rate(p_rate);
					p_arr = clip16(arr_of(p_psc, p_rate));
					p_ccr2 = second_ticks(p_rate, p_psc, v);
				end
				return ST_OK;
			end
			default: return ST_INVALID;
		endcase
	endfunction

	function automatic record_t snapshot(status_t st);
		record_t r;
		r.status = st;
		r.rate = p_rate;
		r.psc = p_psc;
		r.arr = p_arr;
		r.ccr_main = p_ccr;
		r.ccr_second = p_ccr2;
		return r;
	endfunction

	task automatic report(string what, logic [15:0] got, logic [15:0] want);
		mismatches++;
		$display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
	endtask

	// register write; only issued while the block is idle
	task automatic write_limit(logic idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_MAX_ON) lim_on_us = val;
		else lim_rate = val;
	endtask

	task automatic wait_idle();
		while (record_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// offer one request transaction; the expected record is queued at acceptance.
	// s_tvalid stays high across back-to-back items, so it is lowered only before a gap.
	task automatic send(req_t req, logic [31:0] v, bit typed = 0,
		record_t rec = '{ST_OK, 0, 0, 0, 0, 0});
		int gap;
		status_t st;
		gap = tx_jitter ? $urandom_range(0, 16) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tuser <= req;
		do @(posedge clk); while (!s_tready);
		st = update_record(req, v);
		record_q.push_back(typed ? rec : snapshot(st));
		sent++;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		wait_idle();
	endtask

	// receiver: random stalls per transaction, plus a long hold-off when requested
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = rx_jitter ? $urandom_range(0, 16) : 0;
			if (rx_holdoff > 0) begin
				stall = rx_holdoff;
				rx_holdoff = 0;
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// result checker
	always @(posedge clk) begin
		record_t w;
		status_t got_st;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (record_q.size() == 0) begin
				mismatches++;
				$display("[%0t] result transaction with nothing expected", $realtime);
			end else begin
				w = record_q.pop_front();
				got_st = status_t'(m_tdata[1:0]);
				if (got_st != w.status) report("status", got_st, w.status);
				if (m_tdata[17:2] != w.rate) report("frame_rate", m_tdata[17:2], w.rate);
				if (m_tdata[33:18] != w.psc) report("prescaler", m_tdata[33:18], w.psc);
				if (m_tdata[49:34] != w.arr) report("period", m_tdata[49:34], w.arr);
				if (m_tdata[65:50] != w.ccr_main)
					report("compare_main", m_tdata[65:50], w.ccr_main);
				if (m_tdata[81:66] != w.ccr_second)
					report("compare_second", m_tdata[81:66], w.ccr_second);
			end
		end
	end

	// random request biased toward meaningful values for the current limits
	task automatic random_request();
		int pick;
		req_t req;
		logic [31:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 3) req = REQ_BAD;
		else req = req_t'($urandom_range(0, 2));
		pick = $urandom_range(0, 99);
		if (pick < 8) v = $urandom();
		else if (pick < 14) v = 0;
		else case (req)
			REQ_MAIN: v = $urandom_range(1, int'(lim_on_us) + 50);
			REQ_RATE: v = (pick < 60) ? $urandom_range(1, int'(lim_rate) + 5)
				: $urandom_range(1, (lim_rate > 200) ? 200 : int'(lim_rate) + 5);
			REQ_SECOND: v = (pick < 70) ? $urandom_range(1, 20000) : $urandom_range(1, 400000);
			default: v = $urandom();
		endcase
		send(req, v);
	endtask

	row_t rows[$];

	initial begin
		record_t z;
		z = '{ST_OK, 0, 0, 0, 0, 0};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_we = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		lim_on_us = MAX_ON_RST_C;
		lim_rate = MAX_RATE_RST_C;
		{p_rate, p_psc, p_arr, p_ccr, p_ccr2, p_on} = '0;
		p_on2 = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part: reset record, limits, clamps, clears and unknown type
		rows = '{
			'{REQ_MAIN, 32'd0, 1, z},
			'{REQ_BAD, 32'd5, 1, '{ST_INVALID, 0, 0, 0, 0, 0}},
			'{REQ_MAIN, 32'd70000, 1, '{ST_INVALID, 0, 0, 0, 0, 0}},
			'{REQ_MAIN, 32'd5001, 1, '{ST_INVALID, 0, 0, 0, 0, 0}},
			'{REQ_RATE, 32'd61, 1, '{ST_INVALID, 0, 0, 0, 0, 0}},
			'{REQ_RATE, 32'd30, 1, '{ST_OK, 30, 0, 0, 0, 0}},
			'{REQ_MAIN, 32'd1000, 0, z},
			'{REQ_SECOND, 32'd2000, 0, z},
			'{REQ_SECOND, 32'hffffffff, 0, z},
			'{REQ_RATE, 32'd60, 0, z},
			'{REQ_MAIN, 32'd5000, 0, z},
			'{REQ_MAIN, 32'd1, 0, z},
			'{REQ_RATE, 32'd1, 0, z},
			'{REQ_RATE, 32'd0, 1, z},
			'{REQ_MAIN, 32'd1666, 0, z},
			'{REQ_RATE, 32'd60, 0, z},
			'{REQ_MAIN, 32'd0, 0, z},
			'{REQ_SECOND, 32'd0, 0, z},
			'{REQ_RATE, 32'd60, 0, z},
			'{REQ_BAD, 32'hffffffff, 0, z},
			'{REQ_MAIN, 32'hffffffff, 0, z},
			'{REQ_SECOND, 32'd1, 0, z}
		};
		foreach (rows[i]) send(rows[i].req, rows[i].value, rows[i].typed, rows[i].rec);
		settle();

		// random phases across limit settings, extremes included
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: begin write_limit(CFG_MAX_ON, 16'd5000); write_limit(CFG_MAX_RATE, 16'd60); end
				1: begin write_limit(CFG_MAX_ON, 16'hffff); write_limit(CFG_MAX_RATE, 16'hffff); end
				2: begin write_limit(CFG_MAX_ON, 16'd1); write_limit(CFG_MAX_RATE, 16'd1); end
				3: begin write_limit(CFG_MAX_ON, 16'hffff); write_limit(CFG_MAX_RATE, 16'd3000); end
				default: begin
					write_limit(CFG_MAX_ON, 16'($urandom_range(1, 65535)));
					write_limit(CFG_MAX_RATE, 16'($urandom_range(1, 500)));
				end
			endcase
			tx_jitter = (ph != 1);
			rx_jitter = (ph != 3);
			for (int n = 0; n < 326; n++) begin
				if (ph == 2 && n == 40) rx_holdoff = 1500;  // block fills and stalls input
				if (ph == 4 && n == 100) begin
					s_tvalid <= 1'b0;
					while (record_q.size() != 0) @(posedge clk);
				end
				random_request();
			end
			settle();
		end

		$display("covered %0d requests and %0d results over directed cases and 5 limit settings",
			sent, results_seen);
		$display("stalls, back-to-back streams and a long receiver hold-off were exercised");
		if (mismatches == 0 && record_q.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, record_q.size());
			$display("testbench: done, errors");
		end
		$finish;
	end
endmodule

### led_strobe_timer_calc.f
+incdir+sv
sv/lstc_pkg.sv
sv/lstc_div.sv
sv/led_strobe_timer_calc.sv
tb/testbench.sv
